### rtl/md4_pkg.sv
// ----------------------------------------------------------------------------
// MD4 package
// Payload types, command and status types, constants and step functions
// shared by the MD4 hash engine modules.
// ----------------------------------------------------------------------------
package md4_pkg;

   typedef struct packed {
      logic [31:0] data_word;
      logic [5:0]  valid_bits;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [31:0] word_d;
   } rsp_type;

   typedef enum logic [2:0] {
      SRC_DATA,
      SRC_TAIL,
      SRC_PAD,
      SRC_ZERO,
      SRC_LEN_LO,
      SRC_LEN_HI
   } src_type;

   typedef struct packed {
      logic       push;
      src_type    src;
      logic       count_len;
      logic       load_work;
      logic       step;
      logic [1:0] round;
      logic [3:0] idx;
      logic       finish;
      logic       emit;
      logic       clear;
   } cmd_type;

   typedef struct packed {
      logic [3:0] pos;
   } status_type;

   localparam logic [31:0] IV_A      = 32'h67452301;
   localparam logic [31:0] IV_B      = 32'hefcdab89;
   localparam logic [31:0] IV_C      = 32'h98badcfe;
   localparam logic [31:0] IV_D      = 32'h10325476;
   localparam logic [31:0] K_ROUND_G = 32'h5a827999;
   localparam logic [31:0] K_ROUND_H = 32'h6ed9eba1;
   localparam logic [7:0]  PAD_BYTE  = 8'h80;
   localparam logic [5:0]  FULL_BITS = 6'd32;

   localparam logic [1:0]  ROUND_F   = 2'd0;
   localparam logic [1:0]  ROUND_G   = 2'd1;
   localparam logic [1:0]  ROUND_H   = 2'd2;
   localparam logic [3:0]  IDX_LAST  = 4'd15;
   localparam logic [3:0]  POS_LEN   = 4'd14;
   localparam logic [3:0]  POS_LAST  = 4'd15;

   function automatic logic [4:0] shift_amount(input logic [1:0] round,
                                               input logic [1:0] lane);
      logic [4:0] s;
      begin
         s = 5'd3;
         case (round)
            ROUND_F: begin
               case (lane)
                  2'd1:    s = 5'd7;
                  2'd2:    s = 5'd11;
                  2'd3:    s = 5'd19;
                  default: s = 5'd3;
               endcase
            end
            ROUND_G: begin
               case (lane)
                  2'd1:    s = 5'd5;
                  2'd2:    s = 5'd9;
                  2'd3:    s = 5'd13;
                  default: s = 5'd3;
               endcase
            end
            default: begin
               case (lane)
                  2'd1:    s = 5'd9;
                  2'd2:    s = 5'd11;
                  2'd3:    s = 5'd15;
                  default: s = 5'd3;
               endcase
            end
         endcase
         return s;
      end
   endfunction

   function automatic logic [3:0] msg_index(input logic [1:0] round,
                                            input logic [3:0] idx);
      logic [3:0] m;
      begin
         case (round)
            ROUND_F: m = idx;
            ROUND_G: m = {idx[1:0], idx[3:2]};
            default: m = {idx[0], idx[1], idx[2], idx[3]};
         endcase
         return m;
      end
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      begin
         t = {x, x} << s;
         return t[63:32];
      end
   endfunction

endpackage

### rtl/md4_datapath.sv
// ----------------------------------------------------------------------------
// MD4 datapath
// Block buffer, word position, bit length, chaining and working words,
// padding word builder, round step unit and digest register.
// ----------------------------------------------------------------------------
module md4_datapath (
   input  logic                clock,
   input  logic                reset,
   input  md4_pkg::req_type    req_data,
   input  md4_pkg::cmd_type    cmd,
   output md4_pkg::status_type status,
   output md4_pkg::rsp_type    rsp_data
);
   import md4_pkg::*;

   logic [31:0] buf_ff [16];
   logic [3:0]  pos_ff;
   logic [63:0] len_ff;
   logic [31:0] chain_ff [4];
   logic [31:0] wa_ff, wb_ff, wc_ff, wd_ff;
   rsp_type     rsp_ff;

   logic [1:0]  full_bytes;
   logic [2:0]  rem_bits;
   logic [31:0] tail_word;
   logic [31:0] push_word;
   logic [5:0]  add_bits;
   logic [31:0] f_val;
   logic [31:0] k_val;
   logic [31:0] m_val;
   logic [31:0] sum_val;
   logic [31:0] anew;

   assign full_bytes = req_data.valid_bits[4:3];
   assign rem_bits   = req_data.valid_bits[2:0];

   always_comb begin
      tail_word = '0;
      for (int b = 0; b < 4; b++) begin
         if (2'(b) < full_bytes) begin
            tail_word[8*b +: 8] = req_data.data_word[8*b +: 8];
         end else if (2'(b) == full_bytes) begin
            tail_word[8*b +: 8] = (req_data.data_word[8*b +: 8] & ~(8'hff >> rem_bits))
                                | (PAD_BYTE >> rem_bits);
         end
      end
   end

   always_comb begin
      case (cmd.src)
         SRC_DATA:   push_word = req_data.data_word;
         SRC_TAIL:   push_word = tail_word;
         SRC_PAD:    push_word = {24'd0, PAD_BYTE};
         SRC_LEN_LO: push_word = len_ff[31:0];
         SRC_LEN_HI: push_word = len_ff[63:32];
         default:    push_word = '0;
      endcase
   end

   assign add_bits = (req_data.last && !req_data.valid_bits[5]) ?
                     {1'b0, req_data.valid_bits[4:0]} : FULL_BITS;

   always_comb begin
      case (cmd.round)
         ROUND_F: begin
            f_val = (wb_ff & wc_ff) | (~wb_ff & wd_ff);
            k_val = '0;
         end
         ROUND_G: begin
            f_val = (wb_ff & wc_ff) | (wb_ff & wd_ff) | (wc_ff & wd_ff);
            k_val = K_ROUND_G;
         end
         default: begin
            f_val = wb_ff ^ wc_ff ^ wd_ff;
            k_val = K_ROUND_H;
         end
      endcase
   end

   assign m_val   = buf_ff[msg_index(cmd.round, cmd.idx)];
   assign sum_val = wa_ff + f_val + m_val + k_val;
   assign anew    = rotl(sum_val, shift_amount(cmd.round, cmd.idx[1:0]));

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         buf_ff[pos_ff] <= push_word;
      end
      if (cmd.load_work) begin
         wa_ff <= chain_ff[0];
         wb_ff <= chain_ff[1];
         wc_ff <= chain_ff[2];
         wd_ff <= chain_ff[3];
      end else if (cmd.step) begin
         wa_ff <= wd_ff;
         wb_ff <= anew;
         wc_ff <= wb_ff;
         wd_ff <= wc_ff;
      end
      if (cmd.emit) begin
         rsp_ff.word_a <= chain_ff[0];
         rsp_ff.word_b <= chain_ff[1];
         rsp_ff.word_c <= chain_ff[2];
         rsp_ff.word_d <= chain_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_ff      <= '0;
         len_ff      <= '0;
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
      end else begin
         if (cmd.push) begin
            pos_ff <= pos_ff + 4'd1;
         end
         if (cmd.count_len) begin
            len_ff <= len_ff + 64'(add_bits);
         end
         if (cmd.finish) begin
            chain_ff[0] <= chain_ff[0] + wa_ff;
            chain_ff[1] <= chain_ff[1] + wb_ff;
            chain_ff[2] <= chain_ff[2] + wc_ff;
            chain_ff[3] <= chain_ff[3] + wd_ff;
         end
      end
   end

   assign status.pos = pos_ff;
   assign rsp_data   = rsp_ff;

endmodule

### rtl/md4_ctrl.sv
// ----------------------------------------------------------------------------
// MD4 controller
// Sequences word intake, padding, length words, the 48 compression steps
// and digest delivery.
// ----------------------------------------------------------------------------
module md4_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_last,
   input  logic                req_full,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  md4_pkg::status_type status,
   output md4_pkg::cmd_type    cmd
);
   import md4_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD80,
      S_PADZ,
      S_LENLO,
      S_LENHI,
      S_STEP,
      S_FINAL,
      S_DONE
   } state_type;

   state_type  state_ff, state_in, ret_ff;
   logic [1:0] round_ff;
   logic [3:0] idx_ff;
   logic       rsp_valid_ff;
   logic       wrap;

   always_comb begin
      cmd       = '0;
      cmd.src   = SRC_ZERO;
      cmd.round = round_ff;
      cmd.idx   = idx_ff;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.push      = 1'b1;
               cmd.count_len = 1'b1;
               if (!req_last) begin
                  cmd.src  = SRC_DATA;
                  state_in = S_IDLE;
               end else if (req_full) begin
                  cmd.src  = SRC_DATA;
                  state_in = S_PAD80;
               end else begin
                  cmd.src  = SRC_TAIL;
                  state_in = S_PADZ;
               end
            end
         end
         S_PAD80: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_PAD;
            state_in = S_PADZ;
         end
         S_PADZ: begin
            if (status.pos == POS_LEN) begin
               state_in = S_LENLO;
            end else begin
               cmd.push = 1'b1;
               cmd.src  = SRC_ZERO;
            end
         end
         S_LENLO: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LEN_LO;
            state_in = S_LENHI;
         end
         S_LENHI: begin
            cmd.push = 1'b1;
            cmd.src  = SRC_LEN_HI;
            state_in = S_DONE;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (idx_ff == IDX_LAST && round_ff == ROUND_H) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            cmd.finish = 1'b1;
            state_in   = ret_ff;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      wrap          = cmd.push && (status.pos == POS_LAST);
      cmd.load_work = wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         round_ff     <= ROUND_F;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wrap) begin
            state_ff <= S_STEP;
            ret_ff   <= state_in;
            round_ff <= ROUND_F;
            idx_ff   <= '0;
         end else begin
            state_ff <= state_in;
            if (cmd.step) begin
               idx_ff <= idx_ff + 4'd1;
               if (idx_ff == IDX_LAST) begin
                  round_ff <= round_ff + 2'd1;
               end
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_emit_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("digest loaded over an untaken result");

   a_step_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_STEP ##1 state_ff == S_STEP) |-> (round_ff == ROUND_F && idx_ff == 4'd0))
      else $error("compression started with a nonzero step count");

   a_step_cause: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_STEP ##1 state_ff == S_STEP) |-> ($past(cmd.push) && $past(status.pos) == POS_LAST))
      else $error("compression started without a full block");

   a_step_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP && round_ff == ROUND_H && idx_ff == IDX_LAST) |=> state_ff == S_FINAL)
      else $error("compression did not end after 48 steps");
`endif

endmodule

### rtl/md4_hash_engine.sv
// ----------------------------------------------------------------------------
// MD4 hash engine
// Streaming MD4 digest of a message given as 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one message word per handshake, bytes low-order first.
//     valid_bits counts the bits used in the last word (1..32, above 32
//     means 32); last marks the final word and starts padding.
//   rsp channel: one digest (words A..D) per message, after the last word.
// Flow:
//   Words are taken back to back; every sixteenth word starts a block
//   compression (48 serial round steps through one step unit and one
//   chaining add), during which req_ready is low. After the last word,
//   the padding, zero words and low and high length words are pushed,
//   with a turn state before the length words and one or two
//   compressions, then the digest is loaded.
// Reset: synchronous; the chaining words return to the MD4 initial values
//   and the word position and bit length clear. The engine does the same
//   after each digest.
// Stall: the digest waits in an output register; the next message may be
//   streamed while it waits, but a further digest holds until it is taken.
// ----------------------------------------------------------------------------
module md4_hash_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  md4_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output md4_pkg::rsp_type rsp_data
);
   import md4_pkg::*;

   cmd_type    cmd;
   status_type status;

   md4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last),
      .req_full  (req_data.valid_bits[5]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   md4_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
